[rtl/lsqe_pkg.sv]
`default_nettype none
package lsqe_pkg;

    localparam int unsigned MaxVertices = 4096;
    localparam int unsigned MaxIndices  = 6144;
    localparam int unsigned CntW        = 14;

    localparam logic [1:0] KIND_VERTEX  = 2'd0;
    localparam logic [1:0] KIND_INDEX   = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic [30:0]        line_width;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [11:0]        index_value;
        logic               last;
    } t_out_item;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_NORM,
        ST_SQX,
        ST_SQZ,
        ST_ROOT,
        ST_SQRT,
        ST_DIVX,
        ST_DIVZ,
        ST_MULX,
        ST_MULZ,
        ST_OFFZ,
        ST_EMIT
    } t_state;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [11:0] idx_add(input logic [3:0] k);
        logic [11:0] r;
        case (k)
            4'd4:    r = 12'd3;
            4'd5:    r = 12'd1;
            4'd6:    r = 12'd2;
            4'd7:    r = 12'd0;
            4'd8:    r = 12'd1;
            4'd9:    r = 12'd2;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/lsqe_if.sv]
`default_nettype none
interface lsqe_in_if;
    import lsqe_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsqe_out_if;
    import lsqe_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/lsqe_iter.sv]
`default_nettype none
// shared restoring unit: 64-bit square root or 31-bit quotient, one bit a cycle
module lsqe_iter import lsqe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_iter_req   i_req,
    input  wire logic [63:0] i_rad,
    input  wire logic [32:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_result
);

    logic [63:0] r_a, r_b, r_c;
    logic [30:0] r_low;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    t_iter_mode  r_mode;

    logic [63:0] rem2, op_x, op_y, diff;
    logic        ge;

    always_comb begin
        rem2 = {r_a[62:0], r_low[30]};
        op_x = (r_mode == ITER_SQRT) ? r_a : rem2;
        op_y = (r_mode == ITER_SQRT) ? (r_c + r_b) : r_b;
        ge   = (op_x >= op_y);
        diff = op_x - op_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= ITER_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_c    <= '0;
                if (i_req.mode == ITER_SQRT) begin
                    r_a   <= i_rad;
                    r_b   <= 64'h4000_0000_0000_0000;
                    r_low <= '0;
                    r_cnt <= 5'd31;
                end else begin
                    r_a   <= {32'd0, i_num[32:1]};
                    r_b   <= {32'd0, i_den};
                    r_low <= {i_num[0], 30'd0};
                    r_cnt <= 5'd30;
                end
            end else if (r_busy) begin
                if (r_mode == ITER_SQRT) begin
                    if (ge) begin
                        r_a <= diff;
                        r_c <= (r_c >> 1) + r_b;
                    end else begin
                        r_c <= r_c >> 1;
                    end
                    r_b <= r_b >> 2;
                end else begin
                    r_a   <= ge ? diff : rem2;
                    r_c   <= {r_c[62:0], ge};
                    r_low <= {r_low[29:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_c[31:0];

endmodule
`default_nettype wire

[rtl/line_segment_quad_expander_unit.sv]
`default_nettype none
// channel  | dir | beat
// i_in     | in  | command, segment endpoints, colour, width
// o_out    | out | vertex, index or drop result
// an add that is not dropped holds the input off through a pre-scale step, normalise
// steps, a square root and two divides on one shared restoring unit, then the MULX,
// MULZ and OFFZ scale states and 10 output beats.
// a line along y skips the unit, a dropped line emits only its drop beat, a clear nothing.
// synchronous active-low reset zeroes both running counts.
// input is held off while a line is in flight; output stalls freeze emission.
module line_segment_quad_expander_unit import lsqe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lsqe_in_if.sink     i_in,
    lsqe_out_if.source  o_out
);

    t_state r_state, n_state;
    t_in_item r_item;
    logic [12:0] r_vused, r_iused, r_vbase;
    logic [32:0] r_ax, r_az;
    logic [63:0] r_prod, r_sum;
    logic [31:0] r_len;
    logic [30:0] r_ux, r_uz;
    logic signed [31:0] r_offx, r_offz;
    logic r_negx, r_negz, r_drop;
    logic [3:0] r_k;
    logic r_ov;
    t_out_item r_out, n_out;

    t_iter_req   iter_req;
    logic        iter_done;
    logic [31:0] iter_res;
    logic [32:0] iter_num;
    logic [31:0] iter_den;

    logic accept, ld;
    logic signed [32:0] dx, dy, dz;
    logic [32:0] m;
    logic [31:0] mul_a, mul_b;
    logic [30:0] mag;
    logic signed [31:0] off_s;
    logic [CntW-1:0] vnext, inext;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign ld = (r_state == ST_EMIT) && (!r_ov || o_out.ready);

    always_comb begin
        dx = 33'(i_in.data.start_x) - 33'(i_in.data.end_x);
        dy = 33'(i_in.data.start_y) - 33'(i_in.data.end_y);
        dz = 33'(i_in.data.start_z) - 33'(i_in.data.end_z);
        vnext = CntW'(r_vused) + CntW'(4);
        inext = CntW'(r_iused) + CntW'(6);
        m = (r_ax > r_az) ? r_ax : r_az;
        mag = 31'((r_prod + 64'h4000_0000) >> 31);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.data.command == CMD_ADD) begin
                    if ((dx == 0 && dy == 0 && dz == 0) ||
                        vnext > CntW'(MaxVertices) || inext > CntW'(MaxIndices)) begin
                        n_state = ST_EMIT;
                    end else if (dx == 0 && dz == 0) begin
                        n_state = ST_MULX;
                    end else begin
                        n_state = ST_PRE;
                    end
                end
            end
            ST_PRE:  n_state = ST_NORM;
            ST_NORM: n_state = (m < 33'h0_4000_0000) ? ST_NORM : ST_SQX;
            ST_SQX:  n_state = ST_SQZ;
            ST_SQZ:  n_state = ST_ROOT;
            ST_ROOT: n_state = ST_SQRT;
            ST_SQRT: n_state = iter_done ? ST_DIVX : ST_SQRT;
            ST_DIVX: n_state = iter_done ? ST_DIVZ : ST_DIVX;
            ST_DIVZ: n_state = iter_done ? ST_MULX : ST_DIVZ;
            ST_MULX: n_state = ST_MULZ;
            ST_MULZ: n_state = ST_OFFZ;
            ST_OFFZ: n_state = ST_EMIT;
            ST_EMIT: n_state = (ld && (r_drop || r_k == 4'd9)) ? ST_IDLE : ST_EMIT;
            default: n_state = ST_IDLE;
        endcase
    end

    // unit control, multiplier operands and result beat
    always_comb begin
        iter_req.start = 1'b0;
        iter_req.mode  = ITER_SQRT;
        iter_num = r_ax;
        iter_den = r_len;
        mul_a = r_ax[31:0];
        mul_b = r_ax[31:0];
        case (r_state)
            ST_SQZ: begin
                mul_a = r_az[31:0];
                mul_b = r_az[31:0];
            end
            ST_ROOT: begin
                iter_req.start = 1'b1;
            end
            ST_SQRT: begin
                if (iter_done) begin
                    iter_req.start = 1'b1;
                    iter_req.mode  = ITER_DIV;
                    iter_den = iter_res;
                end
            end
            ST_DIVX: begin
                if (iter_done) begin
                    iter_req.start = 1'b1;
                    iter_req.mode  = ITER_DIV;
                    iter_num = r_az;
                end
            end
            ST_MULX: begin
                mul_a = {1'b0, r_item.line_width};
                mul_b = {1'b0, r_uz};
            end
            ST_MULZ: begin
                mul_a = {1'b0, r_item.line_width};
                mul_b = {1'b0, r_ux};
            end
            default: begin
            end
        endcase

        off_s = (r_state == ST_MULZ ? r_negx : r_negz) ? -$signed({1'b0, mag})
                                                         : $signed({1'b0, mag});

        n_out = '0;
        if (r_drop) begin
            n_out.kind = KIND_DROPPED;
            n_out.last = 1'b1;
        end else if (r_k < 4'd4) begin
            n_out.kind = KIND_VERTEX;
            if (r_k[1]) begin
                n_out.pos_x = sat34(r_k[0] ? 34'(r_item.end_x) - 34'(r_offx)
                                           : 34'(r_item.end_x) + 34'(r_offx));
                n_out.pos_y = r_item.end_y;
                n_out.pos_z = sat34(r_k[0] ? 34'(r_item.end_z) - 34'(r_offz)
                                           : 34'(r_item.end_z) + 34'(r_offz));
            end else begin
                n_out.pos_x = sat34(r_k[0] ? 34'(r_item.start_x) - 34'(r_offx)
                                           : 34'(r_item.start_x) + 34'(r_offx));
                n_out.pos_y = r_item.start_y;
                n_out.pos_z = sat34(r_k[0] ? 34'(r_item.start_z) - 34'(r_offz)
                                           : 34'(r_item.start_z) + 34'(r_offz));
            end
            n_out.out_red   = r_item.color_red;
            n_out.out_green = r_item.color_green;
            n_out.out_blue  = r_item.color_blue;
        end else begin
            n_out.kind        = KIND_INDEX;
            n_out.index_value = r_vbase[11:0] + idx_add(r_k);
            n_out.last        = (r_k == 4'd9);
        end
    end

    lsqe_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (iter_req),
        .i_rad    (r_sum + r_prod),
        .i_num    (iter_num),
        .i_den    (iter_den),
        .o_done   (iter_done),
        .o_result (iter_res)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == ST_SQZ) begin
            r_sum <= r_prod;
        end
        if (r_state == ST_SQRT && iter_done) begin
            r_len <= iter_res;
        end
        if (r_state == ST_DIVX && iter_done) begin
            r_ux <= iter_res[30:0];
        end
        if (r_state == ST_DIVZ && iter_done) begin
            r_uz <= iter_res[30:0];
        end
        if (r_state == ST_MULZ) begin
            r_offx <= off_s;
        end
        if (r_state == ST_OFFZ) begin
            r_offz <= off_s;
        end
        if (r_state == ST_PRE && m > 33'h0_8000_0000) begin
            r_ax <= r_ax >> 1;
            r_az <= r_az >> 1;
        end
        if (r_state == ST_NORM && m < 33'h0_4000_0000) begin
            r_ax <= r_ax << 1;
            r_az <= r_az << 1;
        end
        if (accept) begin
            r_item <= i_in.data;
            r_ax   <= dx[32] ? 33'(-dx) : 33'(dx);
            r_az   <= dz[32] ? 33'(-dz) : 33'(dz);
            r_ux   <= '0;
            r_uz   <= 31'h4000_0000;
            r_vbase <= r_vused;
            if (dx == 0 && dz == 0) begin
                r_negx <= dy[32];
                r_negz <= 1'b0;
            end else begin
                r_negx <= !dz[32];
                r_negz <= dx[32];
            end
        end
        if (ld) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vused <= '0;
            r_iused <= '0;
            r_drop  <= 1'b0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_k <= '0;
                if (i_in.data.command == CMD_CLEAR) begin
                    r_vused <= '0;
                    r_iused <= '0;
                    r_drop  <= 1'b0;
                end else if ((dx == 0 && dy == 0 && dz == 0) ||
                             vnext > CntW'(MaxVertices) ||
                             inext > CntW'(MaxIndices)) begin
                    r_drop <= 1'b1;
                end else begin
                    r_drop  <= 1'b0;
                    r_vused <= vnext[12:0];
                    r_iused <= inext[12:0];
                end
            end
            if (ld) begin
                r_k  <= r_k + 4'd1;
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire
